// ----- hdl/lfsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lfsc_pkg: shared types, constants and functions of the steering control
// Holds the register map, reset values, the controller/datapath command and
// status structs, and the small lookup and saturation functions.
// ----------------------------------------------------------------------------
package lfsc_pkg;

  // Configuration port.
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    REG_FULL_RANGE  = 2'd0,
    REG_STUCK_START = 2'd1,
    REG_OFFLINE_ROW = 2'd2,
    REG_DEADBAND    = 2'd3
  } reg_idx_e;

  localparam logic [9:0]         FullRangeRst  = 10'd100;
  localparam logic signed [10:0] StuckStartRst = 11'sd100;
  localparam logic [7:0]         OfflineRowRst = 8'd40;
  localparam logic [7:0]         DeadbandRst   = 8'd5;

  // Correction term 12 * |steering| / 100, done as a multiply by
  // round_up(12 * 2^19 / 100) and a shift; exact for |steering| <= 1024.
  localparam int unsigned  CorrShift = 19;
  localparam logic [15:0]  CorrRecip = 16'd62915;

  // Serial divider: the dividend magnitude is at most 250 * 50.
  localparam int unsigned NumW     = 14;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Row thresholds of the gain table.
  localparam logic [7:0] GainRow0 = 8'd24;
  localparam logic [7:0] GainRow1 = 8'd30;
  localparam logic [7:0] GainRow2 = 8'd47;
  localparam logic [7:0] GainRow3 = 8'd54;
  localparam logic [7:0] GainRow4 = 8'd60;

  typedef struct packed {
    logic [9:0]         full_range;
    logic signed [10:0] stuck_start;
    logic [7:0]         offline_row;
    logic [7:0]         deadband;
  } cfg_t;

  typedef struct packed {
    logic load;      // capture the accepted request
    logic corr_en;   // register the angle correction magnitude
    logic prod_en;   // register the dividend and arm the divider
    logic div_step;  // one restoring division step
    logic commit;    // update state and the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic steer;     // request takes the forward steering path
  } dp_status_t;

  // Half of the row dependent gain.
  function automatic logic [5:0] row_gain(input logic [7:0] row);
    logic [5:0] g;
    if (row < GainRow0)      g = 6'd50;
    else if (row < GainRow1) g = 6'd47;
    else if (row < GainRow2) g = 6'd45;
    else if (row < GainRow3) g = 6'd42;
    else if (row < GainRow4) g = 6'd40;
    else                     g = 6'd37;
    return g;
  endfunction

  // Negation that saturates the most negative value to the largest positive.
  function automatic logic signed [10:0] neg11(input logic signed [10:0] v);
    logic signed [10:0] r;
    if (v == 11'sh400) r = 11'sd1023;
    else               r = -v;
    return r;
  endfunction

endpackage

// ----- hdl/lfsc_datapath.sv -----
// ----------------------------------------------------------------------------
// lfsc_datapath: steering arithmetic and state
// Holds the kept steering, mode, frame counters and stuck value, the
// correction multiplier, the serial range divider and the result register.
// ----------------------------------------------------------------------------
module lfsc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lfsc_pkg::ctrl_cmd_t   cmd_i,
  output lfsc_pkg::dp_status_t  status_o,
  input  lfsc_pkg::cfg_t        cfg_i,
  input  logic                  stuck_load_i,
  input  logic signed [10:0]    stuck_wdata_i,
  input  logic                  command_i,
  input  logic signed [7:0]     line_x_end_i,
  input  logic [7:0]            line_start_row_i,
  input  logic [7:0]            line_end_row_i,
  input  logic [7:0]            line_range_i,
  output logic signed [10:0]    wheel_angle_o,
  output logic                  wheel_update_o,
  output logic                  reversing_o
);

  // Kept state.
  logic signed [10:0] steer_q, steer_d;
  logic               reverse_q, reverse_d;
  logic [15:0]        fwd_q, fwd_d;
  logic [15:0]        rev_q, rev_d;
  logic signed [10:0] stuck_q, stuck_d;

  // Captured request.
  logic               center_q;
  logic               lost_q;
  logic signed [7:0]  x_end_q;
  logic [5:0]         gain_q;
  logic [7:0]         range_q;

  // Arithmetic pipeline.
  logic [6:0]                  corr_mag_q;
  logic                        num_neg_q;
  logic [7:0]                  rem_q;
  logic [lfsc_pkg::NumW-1:0]   quo_q;

  // Result register.
  logic signed [10:0] angle_q;
  logic               update_q;
  logic               reversing_q;

  // Correction: magnitude of the steering times the scaled reciprocal.
  logic [10:0] steer_mag;
  logic [26:0] corr_prod;
  assign steer_mag = steer_q[10] ? (~steer_q + 11'd1) : steer_q;
  assign corr_prod = steer_mag * lfsc_pkg::CorrRecip;

  // Dividend: |x_end - corr| * gain, sign kept apart.
  logic signed [9:0] corr_s;
  logic signed [9:0] cx;
  logic [8:0]        cx_mag;
  logic [14:0]       num_full;
  assign corr_s   = steer_q[10] ? -$signed({3'b000, corr_mag_q}) : $signed({3'b000, corr_mag_q});
  assign cx       = $signed({{2{x_end_q[7]}}, x_end_q}) - corr_s;
  assign cx_mag   = cx[9] ? 9'(-cx) : 9'(cx);
  assign num_full = cx_mag * gain_q;

  // Restoring division step.
  logic [8:0] rem_sh;
  logic       q_bit;
  assign rem_sh = {rem_q, quo_q[lfsc_pkg::NumW-1]};
  assign q_bit  = (rem_sh >= {1'b0, range_q});

  assign status_o.steer = !center_q && !lost_q && !reverse_q;

  // Next steering and state at commit.
  logic signed [14:0] delta;
  logic signed [15:0] sum;
  logic signed [15:0] fr_pos;
  logic signed [15:0] fr_neg;
  logic signed [10:0] half;
  logic signed [10:0] next_steer;
  logic [10:0]        abs_next;
  logic signed [11:0] diff;
  logic [11:0]        abs_diff;
  logic               update;
  logic signed [10:0] kept_steer;

  always_comb begin
    delta  = (range_q == 8'd0) ? 15'sd0 :
             (num_neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q}));
    sum    = $signed({{5{steer_q[10]}}, steer_q}) + $signed({delta[14], delta});
    fr_pos = $signed({6'b000000, cfg_i.full_range});
    fr_neg = -fr_pos;
    half   = (steer_q + $signed({10'd0, steer_q[10]})) >>> 1;

    next_steer = steer_q;
    reverse_d  = reverse_q;
    fwd_d      = fwd_q;
    rev_d      = rev_q;
    stuck_d    = stuck_q;

    if (lost_q) begin
      if (!reverse_q) begin
        if ({rev_q, 1'b0} > {1'b0, fwd_q}) begin
          next_steer = stuck_q;
          stuck_d    = lfsc_pkg::neg11(stuck_q);
        end else begin
          next_steer = -half;
        end
        reverse_d = 1'b1;
        rev_d     = 16'd1;
      end else begin
        rev_d = (rev_q == 16'hFFFF) ? rev_q : rev_q + 16'd1;
      end
    end else if (reverse_q) begin
      reverse_d  = 1'b0;
      fwd_d      = 16'd1;
      next_steer = lfsc_pkg::neg11(steer_q);
    end else begin
      if (sum > fr_pos)      next_steer = fr_pos[10:0];
      else if (sum < fr_neg) next_steer = fr_neg[10:0];
      else                   next_steer = sum[10:0];
      fwd_d = (fwd_q == 16'hFFFF) ? fwd_q : fwd_q + 16'd1;
    end

    abs_next = next_steer[10] ? (~next_steer + 11'd1) : next_steer;
    diff     = $signed({next_steer[10], next_steer}) - $signed({steer_q[10], steer_q});
    abs_diff = diff[11] ? 12'(-diff) : 12'(diff);
    update   = (abs_next < steer_mag) || (abs_diff > {4'd0, cfg_i.deadband});
    kept_steer = update ? next_steer : steer_q;

    steer_d = kept_steer;
    if (center_q) begin
      // Centering touches only the steering.
      steer_d   = 11'sd0;
      reverse_d = reverse_q;
      fwd_d     = fwd_q;
      rev_d     = rev_q;
      stuck_d   = stuck_q;
    end
    if (stuck_load_i) begin
      stuck_d = stuck_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_q   <= 11'sd0;
      reverse_q <= 1'b0;
      fwd_q     <= 16'd0;
      rev_q     <= 16'd0;
      stuck_q   <= lfsc_pkg::StuckStartRst;
    end else begin
      if (cmd_i.commit) begin
        steer_q   <= steer_d;
        reverse_q <= reverse_d;
        fwd_q     <= fwd_d;
        rev_q     <= rev_d;
      end
      if (cmd_i.commit || stuck_load_i) begin
        stuck_q <= stuck_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      center_q <= command_i;
      lost_q   <= (line_start_row_i > cfg_i.offline_row);
      x_end_q  <= line_x_end_i;
      gain_q   <= lfsc_pkg::row_gain(line_end_row_i);
      range_q  <= line_range_i;
    end
    if (cmd_i.corr_en) begin
      corr_mag_q <= corr_prod[lfsc_pkg::CorrShift+6:lfsc_pkg::CorrShift];
    end
    if (cmd_i.prod_en) begin
      num_neg_q <= cx[9];
      rem_q     <= 8'd0;
      quo_q     <= num_full[lfsc_pkg::NumW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? 8'(rem_sh - {1'b0, range_q}) : rem_sh[7:0];
      quo_q <= {quo_q[lfsc_pkg::NumW-2:0], q_bit};
    end
    if (cmd_i.commit) begin
      angle_q     <= center_q ? 11'sd0 : lfsc_pkg::neg11(kept_steer);
      update_q    <= center_q ? 1'b1 : update;
      reversing_q <= reverse_d;
    end
  end

  assign wheel_angle_o  = angle_q;
  assign wheel_update_o = update_q;
  assign reversing_o    = reversing_q;

endmodule

// ----- hdl/lfsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfsc_ctrl: sequencing controller
// Steps steering requests through correction, dividend, division and commit
// and others from correction to commit; owns input stall and result valid flag.
// ----------------------------------------------------------------------------
module lfsc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  lfsc_pkg::dp_status_t  status_i,
  output lfsc_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORR,
    S_PROD,
    S_DIV,
    S_DONE
  } state_e;

  localparam logic [lfsc_pkg::DivCntW-1:0] DivLast =
    (lfsc_pkg::DivCntW)'(lfsc_pkg::DivSteps - 1);

  state_e                      state_q;
  logic [lfsc_pkg::DivCntW-1:0] cnt_q;
  logic                        out_valid_q;
  logic                        can_commit;

  assign can_commit = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.corr_en  = (state_q == S_CORR);
    cmd_o.prod_en  = (state_q == S_PROD);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.commit   = (state_q == S_DONE) && can_commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A commit refills the result register even as the old result leaves.
      if ((state_q == S_DONE) && can_commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CORR;
          end
        end
        S_CORR: begin
          state_q <= status_i.steer ? S_PROD : S_DONE;
        end
        S_PROD: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (can_commit) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/line_follow_steering_control_top.sv -----
// ----------------------------------------------------------------------------
// line_follow_steering_control_top: line following steering control
// One request per camera frame carries a detected line segment; one result
// per request carries the wheel angle, whether it is commanded, and the
// reverse mode flag.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                   | Payload
//  ---------+-----------+-----------------------------+---------------------------
//  in       | request   | in_valid_i / in_stall_o     | command, x end, rows, range
//  out      | result    | out_valid_o / out_stall_i   | wheel angle, update, reverse
//  config   | APB write | psel, penable, pwrite       | four registers at 4*i
//
// A steering request goes from acceptance to the result register through the
// angle correction multiply, the dividend, the one-bit-per-cycle restoring
// divider by the segment range, and the commit. Center, line-lost and
// reacquire requests skip the dividend and the divider. Reset clears the
// steering, mode and counters and loads the register reset values. A stalled
// result holds the commit of the following request.
// ----------------------------------------------------------------------------
module line_follow_steering_control_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic signed [7:0]            line_x_end_i,
  input  logic [7:0]                   line_start_row_i,
  input  logic [7:0]                   line_end_row_i,
  input  logic [7:0]                   line_range_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [10:0]           wheel_angle_o,
  output logic                         wheel_update_o,
  output logic                         reversing_o,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lfsc_pkg::AddrW-1:0]   paddr,
  input  logic [lfsc_pkg::DataW-1:0]   pwdata,
  output logic [lfsc_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  // The configuration registers. A write to the stuck start value also
  // reloads the stored stuck steering in the datapath.
  lfsc_pkg::cfg_t      cfg_q;
  lfsc_pkg::reg_idx_e  reg_idx;
  logic                cfg_wr;
  logic                stuck_load;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign reg_idx    = lfsc_pkg::reg_idx_e'(paddr[3:2]);
  assign stuck_load = cfg_wr && (reg_idx == lfsc_pkg::REG_STUCK_START);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_range  <= lfsc_pkg::FullRangeRst;
      cfg_q.stuck_start <= lfsc_pkg::StuckStartRst;
      cfg_q.offline_row <= lfsc_pkg::OfflineRowRst;
      cfg_q.deadband    <= lfsc_pkg::DeadbandRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lfsc_pkg::REG_FULL_RANGE:  cfg_q.full_range  <= pwdata[9:0];
        lfsc_pkg::REG_STUCK_START: cfg_q.stuck_start <= pwdata[10:0];
        lfsc_pkg::REG_OFFLINE_ROW: cfg_q.offline_row <= pwdata[7:0];
        lfsc_pkg::REG_DEADBAND:    cfg_q.deadband    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data: unsigned fields zero extended, the stuck start sign extended.
  always_comb begin
    unique case (reg_idx)
      lfsc_pkg::REG_FULL_RANGE:  prdata = {22'd0, cfg_q.full_range};
      lfsc_pkg::REG_STUCK_START: prdata = {{21{cfg_q.stuck_start[10]}}, cfg_q.stuck_start};
      lfsc_pkg::REG_OFFLINE_ROW: prdata = {24'd0, cfg_q.offline_row};
      lfsc_pkg::REG_DEADBAND:    prdata = {24'd0, cfg_q.deadband};
      default:                   prdata = '0;
    endcase
  end

  // The controller sequences each request; the datapath does the arithmetic.
  lfsc_pkg::ctrl_cmd_t  cmd;
  lfsc_pkg::dp_status_t status;

  lfsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lfsc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_i            (cfg_q),
    .stuck_load_i     (stuck_load),
    .stuck_wdata_i    (pwdata[10:0]),
    .command_i        (command_i),
    .line_x_end_i     (line_x_end_i),
    .line_start_row_i (line_start_row_i),
    .line_end_row_i   (line_end_row_i),
    .line_range_i     (line_range_i),
    .wheel_angle_o    (wheel_angle_o),
    .wheel_update_o   (wheel_update_o),
    .reversing_o      (reversing_o)
  );

`ifndef SYNTH
  // An accepted request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted but block not busy afterwards");

  // A new result appears only through a commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.commit))
    else $error("result valid without a commit");

  // A commit never overwrites a result that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !(out_valid_o && out_stall_i))
    else $error("commit over a stalled result");

  // The negated angle saturates and never reaches the most negative code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wheel_angle_o != 11'sh400))
    else $error("wheel angle negation overflowed");
`endif

endmodule

// ----- test/lfsc_steering_checker.sv -----
// ----------------------------------------------------------------------------
// lfsc_steering_checker: result checker for the steering control
// Watches the request, result and register ports, keeps its own copy of the
// steering state and registers, predicts each wheel command and compares it.
// ----------------------------------------------------------------------------
module lfsc_steering_checker
  import lfsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_stall_i,
  input  logic                command_i,
  input  logic signed [7:0]   line_x_end_i,
  input  logic [7:0]          line_start_row_i,
  input  logic [7:0]          line_end_row_i,
  input  logic [7:0]          line_range_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_stall_i,
  input  logic signed [10:0]  wheel_angle_i,
  input  logic                wheel_update_i,
  input  logic                reversing_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [AddrW-1:0]    paddr_i,
  input  logic [DataW-1:0]    pwdata_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  typedef struct packed {
    logic signed [10:0] angle;
    logic               update;
    logic               reversing;
  } wheel_cmd_t;

  cfg_t               cfg;
  logic signed [10:0] steer;
  logic signed [10:0] stuck_angle;
  logic               reverse;
  logic [15:0]        fwd_frames;
  logic [15:0]        rev_frames;
  wheel_cmd_t         wheel_cmd_q[$];
  wheel_cmd_t         due;
  int                 mismatches;

  function automatic int negate_sat(input int v);
    return (v <= -1024) ? 1023 : -v;
  endfunction

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int gain_half(input logic [7:0] row);
    int g;
    if (row < 8'd24)      g = 100;
    else if (row < 8'd30) g = 95;
    else if (row < 8'd47) g = 90;
    else if (row < 8'd54) g = 85;
    else if (row < 8'd60) g = 80;
    else                  g = 75;
    return g / 2;
  endfunction

  // Advances the kept steering state by one frame and returns the command.
  function automatic wheel_cmd_t predict_frame(input logic cmd, input int x_end,
                                               input int start_row,
                                               input logic [7:0] end_row,
                                               input int seg_range);
    int         cur;
    int         nxt;
    int         cx;
    int         delta;
    int         limit;
    logic       hit;
    wheel_cmd_t r;
    cur = steer;
    if (cmd) begin
      steer       = '0;
      r.angle     = '0;
      r.update    = 1'b1;
      r.reversing = reverse;
      return r;
    end
    if (start_row > int'(cfg.offline_row)) begin
      nxt = cur;
      if (!reverse) begin
        if (2 * int'(rev_frames) > int'(fwd_frames)) begin
          nxt         = stuck_angle;
          stuck_angle = 11'(negate_sat(stuck_angle));
        end else begin
          nxt = -(cur / 2);
        end
        reverse    = 1'b1;
        rev_frames = '0;
      end
    end else if (reverse) begin
      reverse    = 1'b0;
      fwd_frames = '0;
      nxt        = negate_sat(cur);
    end else begin
      cx    = x_end - (12 * cur) / 100;
      delta = (seg_range != 0) ? (cx * gain_half(end_row)) / seg_range : 0;
      limit = int'(cfg.full_range);
      nxt   = cur + delta;
      if (nxt > limit)  nxt = limit;
      if (nxt < -limit) nxt = -limit;
    end
    hit = (magnitude(nxt) < magnitude(cur)) ||
          (magnitude(nxt - cur) > int'(cfg.deadband));
    if (hit) steer = 11'(nxt);
    if (reverse) begin
      if (rev_frames != 16'hFFFF) rev_frames = rev_frames + 16'd1;
    end else begin
      if (fwd_frames != 16'hFFFF) fwd_frames = fwd_frames + 16'd1;
    end
    r.angle     = 11'(negate_sat(int'(steer)));
    r.update    = hit;
    r.reversing = reverse;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.full_range  = FullRangeRst;
      cfg.stuck_start = StuckStartRst;
      cfg.offline_row = OfflineRowRst;
      cfg.deadband    = DeadbandRst;
      steer           = '0;
      stuck_angle     = StuckStartRst;
      reverse         = 1'b0;
      fwd_frames      = '0;
      rev_frames      = '0;
      mismatches      = 0;
      wheel_cmd_q.delete();
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        if (wheel_cmd_q.size() == 0) begin
          $display("%0t: result with no request waiting: angle %0d update %0b reversing %0b",
                   $time, wheel_angle_i, wheel_update_i, reversing_i);
          mismatches++;
        end else begin
          due = wheel_cmd_q.pop_front();
          if (wheel_angle_i !== due.angle) begin
            $display("%0t: wheel_angle expected %0d, actual %0d",
                     $time, due.angle, wheel_angle_i);
            mismatches++;
          end
          if (wheel_update_i !== due.update) begin
            $display("%0t: wheel_update expected %0b, actual %0b",
                     $time, due.update, wheel_update_i);
            mismatches++;
          end
          if (reversing_i !== due.reversing) begin
            $display("%0t: reversing expected %0b, actual %0b",
                     $time, due.reversing, reversing_i);
            mismatches++;
          end
        end
      end
      if (req_valid_i && !req_stall_i) begin
        wheel_cmd_q.push_back(predict_frame(command_i, int'(line_x_end_i),
                                            int'(line_start_row_i), line_end_row_i,
                                            int'(line_range_i)));
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          REG_FULL_RANGE:  cfg.full_range = pwdata_i[9:0];
          REG_STUCK_START: begin
            cfg.stuck_start = pwdata_i[10:0];
            stuck_angle     = pwdata_i[10:0];
          end
          REG_OFFLINE_ROW: cfg.offline_row = pwdata_i[7:0];
          REG_DEADBAND:    cfg.deadband = pwdata_i[7:0];
          default: ;
        endcase
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= wheel_cmd_q.size();
  end

endmodule

// ----- test/line_follow_steering_control_top_tb.sv -----
// ----------------------------------------------------------------------------
// line_follow_steering_control_top_tb: testbench of the steering control
// Drives camera frame requests and register writes with random idling on both
// channels; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module line_follow_steering_control_top_tb;
  import lfsc_pkg::*;

  localparam int ClkPeriod   = 8;
  localparam int ResetCycles = 6;
  // Covers a steering request with ample margin.
  localparam int DrainCycles = 40;
  // Far beyond the slowest correct run of about a thousand requests.
  localparam int RunLimit    = 2_000_000;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = 1'b0;
  logic signed [7:0]  line_x_end_i = '0;
  logic [7:0]         line_start_row_i = '0;
  logic [7:0]         line_end_row_i = '0;
  logic [7:0]         line_range_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [10:0] wheel_angle_o;
  logic               wheel_update_o;
  logic               reversing_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [DataW-1:0]   pwdata = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  // When set, neither the request sender nor the result receiver idles.
  logic               no_idle = 1'b0;
  // The line-lost threshold currently programmed, so that random frames can
  // be steered toward both sides of it.
  logic [7:0]         offline_now = OfflineRowRst;
  int                 fail_count;
  int                 pending;

  line_follow_steering_control_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .line_x_end_i     (line_x_end_i),
    .line_start_row_i (line_start_row_i),
    .line_end_row_i   (line_end_row_i),
    .line_range_i     (line_range_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .wheel_angle_o    (wheel_angle_o),
    .wheel_update_o   (wheel_update_o),
    .reversing_o      (reversing_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // The checker sees exactly what the block sees and reports back the number
  // of mismatches and the number of requests still awaiting a result.
  lfsc_steering_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (in_valid_i),
    .req_stall_i      (in_stall_o),
    .command_i        (command_i),
    .line_x_end_i     (line_x_end_i),
    .line_start_row_i (line_start_row_i),
    .line_end_row_i   (line_end_row_i),
    .line_range_i     (line_range_i),
    .rsp_valid_i      (out_valid_o),
    .rsp_stall_i      (out_stall_i),
    .wheel_angle_i    (wheel_angle_o),
    .wheel_update_i   (wheel_update_o),
    .reversing_i      (reversing_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatches_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    #(RunLimit);
    $display("** line_follow_steering_control_top: FAILED **");
    $finish;
  end

  // The result side stalls in about a quarter of the cycles, independently of
  // what the block is doing, so stalls land on every phase of its work.
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 24);
  end

  // One APB write: a setup cycle, then the access cycle, which completes at
  // the edge where pready is seen high, then the bus goes idle so that the
  // next write starts in a step of its own. Called right after a rising edge.
  task automatic reg_write(input reg_idx_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Presents one frame request and holds it until the block accepts it.
  // Sometimes the sender first idles for a while; valid then drops in one
  // step and rises in a later one, never both in the same step. The stall
  // read right after the edge is the value the block had at that edge.
  task automatic send_frame(input logic cmd, input logic signed [7:0] x_end,
                            input logic [7:0] start_row, input logic [7:0] end_row,
                            input logic [7:0] seg_range);
    if (!no_idle && ($urandom_range(99) < 24)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(24, 1)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    line_x_end_i     <= x_end;
    line_start_row_i <= start_row;
    line_end_row_i   <= end_row;
    line_range_i     <= seg_range;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Waits until every request has its result. The first edge is taken before
  // looking, so a request accepted at the previous edge is already counted.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Registers change only with the block idle and nothing in flight.
  task automatic program_regs(input logic [9:0] full_range,
                              input logic signed [10:0] stuck_start,
                              input logic [7:0] offline_row,
                              input logic [7:0] deadband);
    wait_drained();
    reg_write(REG_FULL_RANGE, DataW'(full_range));
    reg_write(REG_STUCK_START, {{(DataW - 11){stuck_start[10]}}, stuck_start});
    reg_write(REG_OFFLINE_ROW, DataW'(offline_row));
    reg_write(REG_DEADBAND, DataW'(deadband));
    offline_now = offline_row;
  endtask

  // A random frame. Most frames keep the line in view, a good share lose it
  // so the reverse entry, hold and reacquire paths all get exercised, and a
  // few are center commands. Small ranges are favored to drive the clamp.
  task automatic send_random_frame();
    int                pick;
    int                range_pick;
    logic [7:0]        start_row;
    logic [7:0]        seg_range;
    logic signed [7:0] x_end;
    pick       = $urandom_range(99);
    range_pick = $urandom_range(99);
    x_end      = 8'($urandom);
    if (pick < 32 && offline_now != 8'd255) begin
      start_row = 8'($urandom_range(255, int'(offline_now) + 1));
    end else begin
      start_row = 8'($urandom_range(int'(offline_now), 0));
    end
    if (range_pick < 5)       seg_range = '0;
    else if (range_pick < 35) seg_range = 8'($urandom_range(8, 1));
    else                      seg_range = 8'($urandom_range(255, 1));
    send_frame(pick < 8, x_end, start_row, 8'($urandom), seg_range);
  endtask

  task automatic random_phase(input logic [9:0] full_range,
                              input logic signed [10:0] stuck_start,
                              input logic [7:0] offline_row,
                              input logic [7:0] deadband, input int frames);
    program_regs(full_range, stuck_start, offline_row, deadband);
    repeat (frames) send_random_frame();
  endtask

  initial begin
    logic [7:0] gain_rows[10];
    gain_rows = '{8'd23, 8'd24, 8'd29, 8'd30, 8'd46, 8'd47, 8'd53, 8'd54,
                  8'd59, 8'd60};
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames with the reset register values: clamp at both ends,
    // a zero range, a center command, and one frame on each side of every
    // gain-table row boundary.
    send_frame(1'b0, 8'sd127, 8'd0, 8'd0, 8'd1);
    send_frame(1'b0, -8'sd128, 8'd0, 8'd255, 8'd1);
    send_frame(1'b0, 8'sd55, 8'd10, 8'd100, 8'd0);
    send_frame(1'b1, 8'sd12, 8'd3, 8'd3, 8'd3);
    foreach (gain_rows[i]) send_frame(1'b0, 8'sd20, 8'd5, gain_rows[i], 8'd7);
    // Lose the line just above the threshold, hold in reverse, center while
    // reversing, reacquire exactly at the threshold, then lose it twice more
    // so that the stuck value is taken and flips sign.
    send_frame(1'b0, 8'sd3, 8'd41, 8'd0, 8'd9);
    send_frame(1'b0, 8'sd3, 8'd255, 8'd0, 8'd9);
    send_frame(1'b1, 8'sd0, 8'd255, 8'd0, 8'd9);
    send_frame(1'b0, 8'sd3, 8'd40, 8'd0, 8'd9);
    send_frame(1'b0, 8'sd3, 8'd200, 8'd0, 8'd9);
    send_frame(1'b0, 8'sd3, 8'd0, 8'd0, 8'd9);
    send_frame(1'b0, 8'sd3, 8'd99, 8'd0, 8'd9);

    // Widest range, the most negative stuck value and no deadband: the stuck
    // value of minus 1024 reaches the steering, so both the wheel angle and
    // the reacquire negation must saturate to plus 1023.
    program_regs(10'd1023, -11'sd1024, 8'd0, 8'd0);
    send_frame(1'b0, 8'sd0, 8'd1, 8'd0, 8'd1);
    send_frame(1'b0, 8'sd0, 8'd0, 8'd0, 8'd1);
    send_frame(1'b0, 8'sd0, 8'd1, 8'd0, 8'd1);
    send_frame(1'b0, 8'sd0, 8'd1, 8'd0, 8'd1);
    send_frame(1'b0, 8'sd0, 8'd0, 8'd0, 8'd1);
    send_frame(1'b0, -8'sd128, 8'd0, 8'd0, 8'd1);

    // Random phases across several register settings, extremes included.
    // The zero clamp phase with the highest threshold never loses the line.
    random_phase(10'd1023, -11'sd1024, 8'd0, 8'd0, 150);
    random_phase(10'd0, 11'sd1023, 8'd255, 8'd255, 100);
    // A long stretch with no idling on either side.
    wait_drained();
    no_idle <= 1'b1;
    random_phase(FullRangeRst, StuckStartRst, OfflineRowRst, DeadbandRst, 200);
    wait_drained();
    no_idle <= 1'b0;
    repeat (3) begin
      random_phase(10'($urandom), 11'($urandom), 8'($urandom),
                   8'($urandom_range(40, 0)), 170);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** line_follow_steering_control_top: PASSED **");
    end else begin
      $display("** line_follow_steering_control_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- line_follow_steering_control_top.f -----
hdl/lfsc_pkg.sv
hdl/lfsc_datapath.sv
hdl/lfsc_ctrl.sv
hdl/line_follow_steering_control_top.sv
test/lfsc_steering_checker.sv
test/line_follow_steering_control_top_tb.sv
